>>> rtl/xsp_pkg.sv
// Shared widths, constants, codes and controller/datapath types of the xorshift128+ generator.
package xsp_pkg;

    localparam int FUNC_W    = 2;
    localparam int BOUND_W   = 32;
    localparam int WORD_W    = 64;
    localparam int HALF_W    = WORD_W / 2;
    localparam int FRAC_W    = 53;
    localparam int SFRAC_W   = 54;
    localparam int CFG_IDX_W = 2;

    localparam logic [FUNC_W-1:0] FUNC_SEED = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_RAW  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_BND  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_SEED_FIRST  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEED_SECOND = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SEED_MODE   = 2'd2;

    localparam logic [WORD_W-1:0] LCG_MUL    = 64'd6364136223846793005;
    localparam logic [WORD_W-1:0] LCG_ADD    = 64'd1442695040888963407;
    localparam logic [WORD_W-1:0] GUARD_LOW  = 64'h9E3779B97F4A7C15;
    localparam logic [WORD_W-1:0] GUARD_HIGH = 64'hBF58476D1CE4E5B9;

    localparam int SHIFT_A    = 23;
    localparam int SHIFT_B    = 18;
    localparam int SHIFT_C    = 5;
    localparam int FRAC_SHIFT = WORD_W - FRAC_W;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEED_M0,
        ST_SEED_M1,
        ST_SEED_M2,
        ST_SEED_FIN,
        ST_BND,
        ST_THR_WAIT,
        ST_DRAW,
        ST_CHECK,
        ST_MOD_WAIT,
        ST_EMIT
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_SEED_PAIR,
        OP_MUL0,
        OP_MUL1,
        OP_MUL2,
        OP_SEED_LCG,
        OP_ADVANCE,
        OP_THR_START,
        OP_THR_LOAD,
        OP_MOD_START,
        OP_OUT_LOAD
    } t_op;

    typedef enum logic [1:0] {
        RES_RAW,
        RES_BND,
        RES_ZERO
    } t_res_kind;

    typedef struct packed {
        logic      capture;
        t_op       op;
        t_res_kind kind;
    } t_cmd;

    typedef struct packed {
        logic seed_mode;
        logic bound_small;
        logic top_low;
        logic mod_busy;
        logic mod_done;
    } t_status;

endpackage

>>> rtl/xsp_ifs.sv
// Valid/ready channel interfaces: input items, result items and configuration writes.
interface xsp_in_if import xsp_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [FUNC_W-1:0]  func;
    logic [BOUND_W-1:0] bound;

    modport source (output valid, output func, output bound, input ready);
    modport sink   (input valid, input func, input bound, output ready);
endinterface

interface xsp_out_if import xsp_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [WORD_W-1:0]         value;
    logic [FRAC_W-1:0]         unit_fraction;
    logic signed [SFRAC_W-1:0] signed_fraction;

    modport source (output valid, output value, output unit_fraction, output signed_fraction,
                    input ready);
    modport sink   (input valid, input value, input unit_fraction, input signed_fraction,
                    output ready);
endinterface

interface xsp_cfg_if import xsp_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [WORD_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/xsp_mod.sv
// Bit-serial restoring remainder unit, one dividend bit per cycle.
module xsp_mod import xsp_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [BOUND_W-1:0] i_dividend,
    input  logic [BOUND_W-1:0] i_divisor,
    output logic               o_busy,
    output logic               o_done,
    output logic [BOUND_W-1:0] o_rem
);

    localparam int CNT_W = $clog2(BOUND_W);

    logic               r_busy;
    logic               r_done;
    logic [CNT_W-1:0]   r_cnt;
    logic [BOUND_W-1:0] r_dvd;
    logic [BOUND_W-1:0] r_dsr;
    logic [BOUND_W-1:0] r_rem;
    logic [BOUND_W-1:0] n_rem;
    logic [BOUND_W:0]   w_trial;
    logic [BOUND_W:0]   w_diff;

    // remainder stays below the divisor, so the trial fits in one extra bit
    assign w_trial = {r_rem, r_dvd[BOUND_W-1]};
    assign w_diff  = w_trial - {1'b0, r_dsr};

    always_comb begin
        if (w_trial >= {1'b0, r_dsr}) begin
            n_rem = w_diff[BOUND_W-1:0];
        end else begin
            n_rem = w_trial[BOUND_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cnt <= CNT_W'(BOUND_W - 1);
            r_dvd <= i_dividend;
            r_dsr <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            r_dvd <= r_dvd << 1;
            r_rem <= n_rem;
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_rem  = r_rem;

    a_last_step_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && !i_start && r_cnt == '0 |=> r_done && !r_busy)
        else $error("remainder unit did not finish after its last step");

    a_rem_below_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> r_rem < r_dsr)
        else $error("remainder not below divisor");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> r_busy && !r_done)
        else $error("remainder unit not busy after start");

endmodule

>>> rtl/xsp_dp.sv
// Datapath: seed registers, generator state, LCG multiplier, remainder unit and result registers.
module xsp_dp import xsp_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    xsp_cfg_if.sink                   i_cfg,
    input  logic [BOUND_W-1:0]        i_bound,
    input  t_cmd                      i_cmd,
    output t_status                   o_status,
    output logic [WORD_W-1:0]         o_value,
    output logic [FRAC_W-1:0]         o_unit_fraction,
    output logic signed [SFRAC_W-1:0] o_signed_fraction
);

    typedef struct packed {
        logic [WORD_W-1:0] lo;
        logic [WORD_W-1:0] hi;
        logic [WORD_W-1:0] raw;
    } t_adv;

    function automatic t_adv advance(input logic [WORD_W-1:0] lo, input logic [WORD_W-1:0] hi);
        logic [WORD_W-1:0] a;
        t_adv              res;
        a       = lo ^ (lo << SHIFT_A);
        res.lo  = hi;
        res.hi  = a ^ hi ^ (a >> SHIFT_B) ^ (hi >> SHIFT_C);
        res.raw = res.hi + hi;
        return res;
    endfunction

    logic [WORD_W-1:0]         r_seed_first;
    logic [WORD_W-1:0]         r_seed_second;
    logic                      r_seed_mode;
    logic [WORD_W-1:0]         r_word_low;
    logic [WORD_W-1:0]         r_word_high;
    logic [BOUND_W-1:0]        r_bound;
    logic [BOUND_W-1:0]        r_thr;
    logic [WORD_W-1:0]         r_raw;
    logic [WORD_W-1:0]         r_prod;
    logic [WORD_W-1:0]         r_acc;
    logic [WORD_W-1:0]         r_value;
    logic [FRAC_W-1:0]         r_unit;
    logic signed [SFRAC_W-1:0] r_sfrac;

    t_adv               w_adv;
    logic [HALF_W-1:0]  w_mul_a;
    logic [HALF_W-1:0]  w_mul_b;
    logic [WORD_W-1:0]  w_prod_hi;
    logic               w_mod_start;
    logic [BOUND_W-1:0] w_mod_dividend;
    logic               w_mod_busy;
    logic               w_mod_done;
    logic [BOUND_W-1:0] w_mod_rem;
    logic [FRAC_W-1:0]  w_unit;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed_first  <= '0;
            r_seed_second <= '0;
            r_seed_mode   <= 1'b0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_SEED_FIRST:  r_seed_first  <= i_cfg.data;
                CFG_SEED_SECOND: r_seed_second <= i_cfg.data;
                CFG_SEED_MODE:   r_seed_mode   <= i_cfg.data[0];
                default: ;
            endcase
        end
    end

    assign w_adv = advance(r_word_low, r_word_high);

    // low 64 bits of seed * LCG_MUL from three 32x32 partial products
    always_comb begin
        w_mul_a = r_seed_first[HALF_W-1:0];
        w_mul_b = LCG_MUL[HALF_W-1:0];
        if (i_cmd.op == OP_MUL1) begin
            w_mul_a = r_seed_first[WORD_W-1:HALF_W];
        end else if (i_cmd.op == OP_MUL2) begin
            w_mul_b = LCG_MUL[WORD_W-1:HALF_W];
        end
    end

    assign w_prod_hi = {r_prod[HALF_W-1:0], {HALF_W{1'b0}}};

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_MUL0 || i_cmd.op == OP_MUL1 || i_cmd.op == OP_MUL2) begin
            r_prod <= {{HALF_W{1'b0}}, w_mul_a} * {{HALF_W{1'b0}}, w_mul_b};
        end
        if (i_cmd.op == OP_MUL1) begin
            r_acc <= r_prod + LCG_ADD;
        end else if (i_cmd.op == OP_MUL2) begin
            r_acc <= r_acc + w_prod_hi;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word_low  <= '0;
            r_word_high <= LCG_ADD;
        end else begin
            unique case (i_cmd.op)
                OP_SEED_PAIR: begin
                    if (r_seed_first == '0 && r_seed_second == '0) begin
                        r_word_low  <= GUARD_LOW;
                        r_word_high <= GUARD_HIGH;
                    end else begin
                        r_word_low  <= r_seed_first;
                        r_word_high <= r_seed_second;
                    end
                end
                OP_SEED_LCG: begin
                    r_word_low  <= r_seed_first;
                    r_word_high <= r_acc + w_prod_hi;
                end
                OP_ADVANCE: begin
                    r_word_low  <= w_adv.lo;
                    r_word_high <= w_adv.hi;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_bound <= i_bound;
        end
        if (i_cmd.op == OP_ADVANCE) begin
            r_raw <= w_adv.raw;
        end
        if (i_cmd.op == OP_THR_LOAD) begin
            r_thr <= w_mod_rem;
        end
    end

    // threshold is (2^32 - bound) mod bound, final value is top mod bound
    assign w_mod_start    = (i_cmd.op == OP_THR_START) || (i_cmd.op == OP_MOD_START);
    assign w_mod_dividend = (i_cmd.op == OP_THR_START) ? (BOUND_W'(0) - r_bound)
                                                       : r_raw[WORD_W-1:HALF_W];

    xsp_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_mod_start),
        .i_dividend (w_mod_dividend),
        .i_divisor  (r_bound),
        .o_busy     (w_mod_busy),
        .o_done     (w_mod_done),
        .o_rem      (w_mod_rem)
    );

    assign w_unit = r_raw[WORD_W-1:FRAC_SHIFT];

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_OUT_LOAD) begin
            unique case (i_cmd.kind)
                RES_RAW: begin
                    r_value <= r_raw;
                    r_unit  <= w_unit;
                    r_sfrac <= {~w_unit[FRAC_W-1], w_unit[FRAC_W-2:0], 1'b0};
                end
                RES_BND: begin
                    r_value <= {{(WORD_W-BOUND_W){1'b0}}, w_mod_rem};
                    r_unit  <= w_unit;
                    r_sfrac <= {~w_unit[FRAC_W-1], w_unit[FRAC_W-2:0], 1'b0};
                end
                default: begin
                    r_value <= '0;
                    r_unit  <= '0;
                    r_sfrac <= '0;
                end
            endcase
        end
    end

    assign o_status.seed_mode   = r_seed_mode;
    assign o_status.bound_small = (r_bound[BOUND_W-1:1] == '0);
    assign o_status.top_low     = (r_raw[WORD_W-1:HALF_W] < r_thr);
    assign o_status.mod_busy    = w_mod_busy;
    assign o_status.mod_done    = w_mod_done;

    assign o_value           = r_value;
    assign o_unit_fraction   = r_unit;
    assign o_signed_fraction = r_sfrac;

endmodule

>>> rtl/xsp_ctrl.sv
// Controller state machine: sequences reseeds, draws, rejection retries and result hand-off.
module xsp_ctrl import xsp_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic [FUNC_W-1:0] i_func,
    output logic              o_in_ready,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    input  t_status           i_status,
    output t_cmd              o_cmd
);

    t_state    r_state;
    t_state    n_state;
    t_res_kind r_kind;
    t_res_kind n_kind;
    logic      r_out_valid;
    logic      n_out_valid;
    logic      w_accept;
    logic      w_out_free;

    assign o_in_ready = (r_state == ST_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_kind      <= RES_RAW;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_kind      <= n_kind;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state       = r_state;
        n_kind        = r_kind;
        o_cmd.capture = w_accept;
        o_cmd.op      = OP_NONE;
        o_cmd.kind    = r_kind;
        n_out_valid   = r_out_valid && !i_out_ready;

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    case (i_func)
                        FUNC_SEED: begin
                            if (i_status.seed_mode) begin
                                o_cmd.op = OP_SEED_PAIR;
                            end else begin
                                n_state = ST_SEED_M0;
                            end
                        end
                        FUNC_RAW: begin
                            o_cmd.op = OP_ADVANCE;
                            n_kind   = RES_RAW;
                            n_state  = ST_EMIT;
                        end
                        FUNC_BND: n_state = ST_BND;
                        default: ;
                    endcase
                end
            end
            ST_SEED_M0: begin
                o_cmd.op = OP_MUL0;
                n_state  = ST_SEED_M1;
            end
            ST_SEED_M1: begin
                o_cmd.op = OP_MUL1;
                n_state  = ST_SEED_M2;
            end
            ST_SEED_M2: begin
                o_cmd.op = OP_MUL2;
                n_state  = ST_SEED_FIN;
            end
            ST_SEED_FIN: begin
                o_cmd.op = OP_SEED_LCG;
                n_state  = ST_IDLE;
            end
            ST_BND: begin
                if (i_status.bound_small) begin
                    n_kind  = RES_ZERO;
                    n_state = ST_EMIT;
                end else begin
                    o_cmd.op = OP_THR_START;
                    n_state  = ST_THR_WAIT;
                end
            end
            ST_THR_WAIT: begin
                if (i_status.mod_done) begin
                    o_cmd.op = OP_THR_LOAD;
                    n_state  = ST_DRAW;
                end
            end
            ST_DRAW: begin
                o_cmd.op = OP_ADVANCE;
                n_state  = ST_CHECK;
            end
            ST_CHECK: begin
                // rejected draw: redraw in place
                if (i_status.top_low) begin
                    o_cmd.op = OP_ADVANCE;
                end else begin
                    o_cmd.op = OP_MOD_START;
                    n_state  = ST_MOD_WAIT;
                end
            end
            ST_MOD_WAIT: begin
                if (i_status.mod_done) begin
                    n_kind  = RES_BND;
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (w_out_free) begin
                    o_cmd.op    = OP_OUT_LOAD;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_out_valid = r_out_valid;

    a_mod_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.op == OP_THR_START || o_cmd.op == OP_MOD_START |-> !i_status.mod_busy)
        else $error("remainder unit started while busy");

    a_emit_hands_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_EMIT && w_out_free |=> r_out_valid && r_state == ST_IDLE)
        else $error("result not handed to output register");

    a_done_when_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_status.mod_done |-> r_state == ST_THR_WAIT || r_state == ST_MOD_WAIT)
        else $error("remainder done outside a wait state");

endmodule

>>> rtl/xorshift128_plus_generator_top.sv
// Top level of the xorshift128+ generator: controller, datapath and channel hookup.
//
// Channels: i_in takes items (func, bound), o_out gives results (value, unit_fraction,
// signed_fraction), i_cfg writes the seed registers (index 0 seed_first, 1 seed_second,
// 2 seed_mode) and is always ready. Write configuration only while the block is idle.
// One item is worked on at a time; i_in.ready is high only when the controller is idle.
// Reseed: no result; pair mode loads the state directly, LCG mode forms it from three 32x32
// partial products through one shared multiplier, then the final add.
// Raw draw: the state advances in the accept cycle, then the emit state loads the result into
// the output register; the next item is taken only once the controller is back in idle.
// Bounded draw: the work is two 32-step passes of the bit-serial remainder unit (threshold,
// then top mod bound), and every rejected draw is redrawn. Bound 0 or 1 answers zero without
// advancing the state.
// Results sit in an output register: the next item is accepted while one waits. If the
// receiver stalls, a finished result waits in the controller until the register frees.
// Reset (synchronous, active low) clears the seed registers and loads the state as if
// seeded from zero in LCG mode; no result is pending afterwards.
module xorshift128_plus_generator_top import xsp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    xsp_in_if.sink     i_in,
    xsp_out_if.source  o_out,
    xsp_cfg_if.sink    i_cfg
);

    t_cmd    w_cmd;
    t_status w_status;

    xsp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_func      (i_in.func),
        .o_in_ready  (i_in.ready),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    xsp_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg             (i_cfg),
        .i_bound           (i_in.bound),
        .i_cmd             (w_cmd),
        .o_status          (w_status),
        .o_value           (o_out.value),
        .o_unit_fraction   (o_out.unit_fraction),
        .o_signed_fraction (o_out.signed_fraction)
    );

endmodule
